[sv/i2c_master_byte_engine_defines.svh]
// Assertion macros for the engine's checking code.
`ifndef I2C_MASTER_BYTE_ENGINE_DEFINES_SVH
`define I2C_MASTER_BYTE_ENGINE_DEFINES_SVH

// Condition must hold in the same cycle as the trigger.
`define I2CM_ASSERT_SAME(label, clk, rst, trig, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |-> (cond)) \
    else $error(msg);

// Condition must hold in the cycle after the trigger.
`define I2CM_ASSERT_NEXT(label, clk, rst, trig, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cond)) \
    else $error(msg);

`endif

[sv/i2cm_pkg.sv]
`timescale 1ns / 1ps
// Package: command codes, queue entry and result types for the I2C byte engine.
package i2cm_pkg;

  typedef enum logic [2:0] {
    CMD_IDLE    = 3'd0,
    CMD_START   = 3'd1,
    CMD_STOP    = 3'd2,
    CMD_RESTART = 3'd3,
    CMD_WRITE   = 3'd4,
    CMD_READ    = 3'd5
  } cmd_t;

  localparam logic [7:0] ACK_POLL_RESET = 8'h09;
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QCNT_W = $clog2(QUEUE_DEPTH + 1);

  // Sequence step numbers
  localparam logic [5:0] WR_BITS_LAST = 6'd24;
  localparam logic [5:0] WR_SCL_LOW   = 6'd25;
  localparam logic [5:0] WR_SDA_REL   = 6'd26;
  localparam logic [5:0] WR_SCL_HIGH  = 6'd27;
  localparam logic [5:0] WR_POLL_STEP = 6'd28;
  localparam logic [5:0] RD_BITS_LAST = 6'd16;
  localparam logic [5:0] RD_SCL_LOW   = 6'd17;
  localparam logic [5:0] RD_ACK_DRIVE = 6'd18;
  localparam logic [5:0] RD_SCL_HIGH  = 6'd19;

  // Classified tick as held in the queue
  typedef struct packed {
    cmd_t       cmd;
    logic [7:0] tx_byte;
    logic       send_nack;
    logic       sda_in;
  } tick_t;

  // Queue handshake toward the back end
  typedef struct packed {
    logic  valid;
    tick_t item;
  } q_src_t;

  typedef struct packed {
    logic [QCNT_W-1:0] count;
  } q_stat_t;

  typedef struct packed {
    logic       scl_out;
    logic       sda_out;
    logic       busy_res;
    logic       done_res;
    logic [7:0] rx_byte;
    logic       ack_received;
    logic       ack_timed_out;
  } res_t;

endpackage

[sv/i2cm_if.sv]
`timescale 1ns / 1ps
// Channel interfaces: input tick channel and result channel.
interface i2cm_in_if;
  logic       valid;
  logic       ready;
  logic [2:0] req_type;
  logic [7:0] tx_byte;
  logic       send_nack;
  logic       sda_in;

  modport source (output valid, req_type, tx_byte, send_nack, sda_in, input ready);
  modport sink (input valid, req_type, tx_byte, send_nack, sda_in, output ready);
endinterface

interface i2cm_out_if;
  logic       valid;
  logic       ready;
  logic       scl_out;
  logic       sda_out;
  logic       busy_res;
  logic       done_res;
  logic [7:0] rx_byte;
  logic       ack_received;
  logic       ack_timed_out;

  modport source (output valid, scl_out, sda_out, busy_res, done_res, rx_byte,
                  ack_received, ack_timed_out, input ready);
  modport sink (input valid, scl_out, sda_out, busy_res, done_res, rx_byte,
                ack_received, ack_timed_out, output ready);
endinterface

[sv/i2c_master_byte_engine.sv]
`timescale 1ns / 1ps
// I2C master byte engine, top level.
//
// Usage: every item on in_ch is one bit-time tick. It may carry a command
// (start, stop, restart, write byte, read byte); a command is taken only when
// the engine is idle, otherwise it is dropped and the running sequence goes on.
// Each tick makes one SCL or SDA change or one acknowledge poll, and gives
// exactly one item on out_ch: pin levels, busy, done, last read byte and ack
// status. cfg_we/cfg_data write the ack poll limit (reset 9) while idle.
// Throughput: one item per cycle, sustained while out_ch is not stalled. The
// front end classifies the request and pushes it into a two-entry queue; the
// back end pops one tick a cycle, updates the sequencer and loads the output
// register. Path: an item is written into a queue entry, then popped, and its
// result is loaded into the output register that drives out_ch.
// Reset (rst, synchronous): engine idle, both lines released, queue and
// output register empty, ack status and read byte cleared.
// Receiver stall: the output register holds; the back end stops popping and
// the queue absorbs up to two more items before in_ch.ready drops.
`include "i2c_master_byte_engine_defines.svh"

module i2c_master_byte_engine (
  input  logic        clk,
  input  logic        rst,
  i2cm_in_if.sink     in_ch,
  i2cm_out_if.source  out_ch,
  input  logic        cfg_we,
  input  logic [7:0]  cfg_data
);

  i2cm_pkg::q_src_t  q_src;
  i2cm_pkg::q_stat_t q_stat;
  logic              q_ready;

  // classify and queue
  i2cm_front u_front (
    .clk     (clk),
    .rst     (rst),
    .in_ch   (in_ch),
    .q_src   (q_src),
    .q_ready (q_ready),
    .q_stat  (q_stat)
  );

  // sequencer and result register
  i2cm_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_src    (q_src),
    .q_ready  (q_ready),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .out_ch   (out_ch)
  );

  // a finished sequence is never reported busy
  `I2CM_ASSERT_SAME(a_done_not_busy, clk, rst, out_ch.valid && out_ch.done_res,
    !out_ch.busy_res, "done and busy in the same result")
  // ack received and timeout are exclusive
  `I2CM_ASSERT_SAME(a_ack_excl, clk, rst, out_ch.valid,
    !(out_ch.ack_received && out_ch.ack_timed_out), "ack received and timed out")
  // queue never overfills
  `I2CM_ASSERT_SAME(a_q_bound, clk, rst, 1'b1,
    q_stat.count <= i2cm_pkg::QCNT_W'(i2cm_pkg::QUEUE_DEPTH), "queue overflow")
  // a full queue with the back end stalled keeps all its items
  `I2CM_ASSERT_NEXT(a_full_stall, clk, rst,
    q_stat.count == i2cm_pkg::QCNT_W'(i2cm_pkg::QUEUE_DEPTH) && !q_ready,
    q_stat.count == i2cm_pkg::QCNT_W'(i2cm_pkg::QUEUE_DEPTH), "queue lost an item")

endmodule

[sv/i2cm_front.sv]
`timescale 1ns / 1ps
// Front end: classifies request codes and queues ticks for the back end.
module i2cm_front (
  input  logic                    clk,
  input  logic                    rst,
  i2cm_in_if.sink                 in_ch,
  output i2cm_pkg::q_src_t        q_src,
  input  logic                    q_ready,
  output i2cm_pkg::q_stat_t       q_stat
);

  i2cm_pkg::tick_t                    entry [i2cm_pkg::QUEUE_DEPTH];
  logic                               wr_ptr;
  logic                               rd_ptr;
  logic [i2cm_pkg::QCNT_W-1:0]        count;
  i2cm_pkg::tick_t                    item_in;
  logic                               push;
  logic                               pop;

  // unused codes six and seven carry no command
  always_comb begin
    item_in.tx_byte   = in_ch.tx_byte;
    item_in.send_nack = in_ch.send_nack;
    item_in.sda_in    = in_ch.sda_in;
    if (in_ch.req_type <= 3'(i2cm_pkg::CMD_READ)) begin
      item_in.cmd = i2cm_pkg::cmd_t'(in_ch.req_type);
    end else begin
      item_in.cmd = i2cm_pkg::CMD_IDLE;
    end
  end

  assign in_ch.ready = (count != i2cm_pkg::QCNT_W'(i2cm_pkg::QUEUE_DEPTH));
  assign push = in_ch.valid && in_ch.ready;
  assign pop  = q_src.valid && q_ready;

  assign q_src.valid = (count != '0);
  assign q_src.item  = entry[rd_ptr];
  assign q_stat.count = count;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      case ({push, pop})
        2'b10:   count <= count + i2cm_pkg::QCNT_W'(1);
        2'b01:   count <= count - i2cm_pkg::QCNT_W'(1);
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) entry[wr_ptr] <= item_in;
  end

endmodule

[sv/i2cm_back.sv]
`timescale 1ns / 1ps
// Back end: bus sequencer state, one tick per popped item, registered result.
module i2cm_back (
  input  logic                clk,
  input  logic                rst,
  input  i2cm_pkg::q_src_t    q_src,
  output logic                q_ready,
  input  logic                cfg_we,
  input  logic [7:0]          cfg_data,
  i2cm_out_if.source          out_ch
);

  logic [7:0]       ack_poll_limit;

  i2cm_pkg::cmd_t   active_command, active_command_next;
  logic [5:0]       step_index, step_index_next;
  logic [1:0]       phase, phase_next;
  logic [7:0]       shift_register, shift_register_next;
  logic [7:0]       poll_count, poll_count_next;
  logic             nack_request, nack_request_next;
  logic             scl_level, scl_level_next;
  logic             sda_level, sda_level_next;
  logic [1:0]       ack_status, ack_status_next;
  logic [7:0]       rx_hold, rx_hold_next;
  logic             fin;
  logic             advance;
  logic [7:0]       poll_inc;

  logic             out_valid;
  i2cm_pkg::res_t   out_res;
  i2cm_pkg::res_t   res_next;
  logic             fire;

  assign fire    = q_src.valid && (!out_valid || out_ch.ready);
  assign q_ready = !out_valid || out_ch.ready;

  always_comb begin
    active_command_next = active_command;
    step_index_next     = step_index;
    phase_next          = phase;
    shift_register_next = shift_register;
    poll_count_next     = poll_count;
    nack_request_next   = nack_request;
    scl_level_next      = scl_level;
    sda_level_next      = sda_level;
    ack_status_next     = ack_status;
    rx_hold_next        = rx_hold;
    fin                 = 1'b0;
    advance             = 1'b1;
    poll_inc            = poll_count + 8'd1;

    // command load, only while idle
    if (active_command == i2cm_pkg::CMD_IDLE && q_src.item.cmd != i2cm_pkg::CMD_IDLE) begin
      active_command_next = q_src.item.cmd;
      step_index_next     = '0;
      phase_next          = '0;
      if (q_src.item.cmd == i2cm_pkg::CMD_WRITE) begin
        shift_register_next = q_src.item.tx_byte;
        poll_count_next     = '0;
        ack_status_next     = '0;
      end else if (q_src.item.cmd == i2cm_pkg::CMD_READ) begin
        shift_register_next = '0;
        nack_request_next   = q_src.item.send_nack;
      end
    end
    poll_inc = poll_count_next + 8'd1;

    case (active_command_next)
      i2cm_pkg::CMD_START, i2cm_pkg::CMD_RESTART: begin
        case (step_index_next)
          6'd0:    sda_level_next = 1'b1;
          6'd1:    scl_level_next = 1'b1;
          6'd2:    sda_level_next = 1'b0;
          default: begin
            scl_level_next = 1'b0;
            fin = 1'b1;
          end
        endcase
      end
      i2cm_pkg::CMD_STOP: begin
        case (step_index_next)
          6'd0:    scl_level_next = 1'b0;
          6'd1:    sda_level_next = 1'b0;
          6'd2:    scl_level_next = 1'b1;
          default: begin
            sda_level_next = 1'b1;
            fin = 1'b1;
          end
        endcase
      end
      i2cm_pkg::CMD_WRITE: begin
        if (step_index_next == 6'd0) begin
          sda_level_next = 1'b1;
        end else if (step_index_next <= i2cm_pkg::WR_BITS_LAST) begin
          // three ticks per bit: SCL low, drive MSB, SCL high
          case (phase_next)
            2'd0: begin
              scl_level_next = 1'b0;
              phase_next = 2'd1;
            end
            2'd1: begin
              sda_level_next      = shift_register_next[7];
              shift_register_next = {shift_register_next[6:0], 1'b0};
              phase_next = 2'd2;
            end
            default: begin
              scl_level_next = 1'b1;
              phase_next = 2'd0;
            end
          endcase
        end else if (step_index_next == i2cm_pkg::WR_SCL_LOW) begin
          scl_level_next = 1'b0;
        end else if (step_index_next == i2cm_pkg::WR_SDA_REL) begin
          sda_level_next = 1'b1;
        end else if (step_index_next == i2cm_pkg::WR_SCL_HIGH) begin
          scl_level_next = 1'b1;
        end else if (step_index_next == i2cm_pkg::WR_POLL_STEP) begin
          if (!q_src.item.sda_in) begin
            ack_status_next = 2'b01;
          end else begin
            poll_count_next = poll_inc;
            if (poll_inc >= ack_poll_limit) begin
              ack_status_next = 2'b10;
            end else begin
              advance = 1'b0;
            end
          end
        end else begin
          scl_level_next = 1'b0;
          fin = 1'b1;
        end
      end
      i2cm_pkg::CMD_READ: begin
        if (step_index_next == 6'd0) begin
          sda_level_next = 1'b1;
        end else if (step_index_next <= i2cm_pkg::RD_BITS_LAST) begin
          if (step_index_next[0]) begin
            scl_level_next = 1'b0;
          end else begin
            scl_level_next      = 1'b1;
            shift_register_next = {shift_register_next[6:0], q_src.item.sda_in};
          end
        end else if (step_index_next == i2cm_pkg::RD_SCL_LOW) begin
          scl_level_next = 1'b0;
        end else if (step_index_next == i2cm_pkg::RD_ACK_DRIVE) begin
          sda_level_next = nack_request_next;
        end else if (step_index_next == i2cm_pkg::RD_SCL_HIGH) begin
          scl_level_next = 1'b1;
        end else begin
          scl_level_next = 1'b0;
          rx_hold_next   = shift_register_next;
          fin = 1'b1;
        end
      end
      default: begin
        advance = 1'b0;
      end
    endcase

    if (fin) begin
      active_command_next = i2cm_pkg::CMD_IDLE;
      step_index_next     = '0;
    end else if (advance) begin
      step_index_next = step_index_next + 6'd1;
    end

    res_next.scl_out       = scl_level_next;
    res_next.sda_out       = sda_level_next;
    res_next.busy_res      = (active_command_next != i2cm_pkg::CMD_IDLE);
    res_next.done_res      = fin;
    res_next.rx_byte       = rx_hold_next;
    res_next.ack_received  = ack_status_next[0];
    res_next.ack_timed_out = ack_status_next[1];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ack_poll_limit <= i2cm_pkg::ACK_POLL_RESET;
      active_command <= i2cm_pkg::CMD_IDLE;
      step_index     <= '0;
      phase          <= '0;
      shift_register <= '0;
      poll_count     <= '0;
      nack_request   <= 1'b0;
      scl_level      <= 1'b1;
      sda_level      <= 1'b1;
      ack_status     <= '0;
      rx_hold        <= '0;
      out_valid      <= 1'b0;
    end else begin
      if (cfg_we) ack_poll_limit <= cfg_data;
      if (fire) begin
        active_command <= active_command_next;
        step_index     <= step_index_next;
        phase          <= phase_next;
        shift_register <= shift_register_next;
        poll_count     <= poll_count_next;
        nack_request   <= nack_request_next;
        scl_level      <= scl_level_next;
        sda_level      <= sda_level_next;
        ack_status     <= ack_status_next;
        rx_hold        <= rx_hold_next;
        out_valid      <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) out_res <= res_next;
  end

  assign out_ch.valid         = out_valid;
  assign out_ch.scl_out       = out_res.scl_out;
  assign out_ch.sda_out       = out_res.sda_out;
  assign out_ch.busy_res      = out_res.busy_res;
  assign out_ch.done_res      = out_res.done_res;
  assign out_ch.rx_byte       = out_res.rx_byte;
  assign out_ch.ack_received  = out_res.ack_received;
  assign out_ch.ack_timed_out = out_res.ack_timed_out;

endmodule

[verif/i2cm_checker.sv]
`timescale 1ns / 1ps
// Checker for the I2C byte engine: watches both channels, predicts each tick and compares.
module i2cm_checker
  import i2cm_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  i2cm_in_if          in_ch,
  i2cm_out_if         out_ch,
  input  logic        cfg_we,
  input  logic [7:0]  cfg_data,
  output int unsigned fail_count,
  output int unsigned pending,
  output logic        engine_busy
);

  // Mirror of the bus sequencer.
  cmd_t       act_cmd;
  logic [5:0] step;
  logic [7:0] shreg;
  logic [7:0] polls;
  logic [7:0] poll_limit;
  logic       nack_req;
  logic       scl_q;
  logic       sda_q;
  logic [1:0] ack_q;
  logic [7:0] rx_q;

  res_t bus_results[$];

  initial begin
    fail_count  = 0;
    pending     = 0;
    engine_busy = 1'b0;
  end

  task automatic report(string what, int unsigned exp_v, int unsigned got_v);
    fail_count++;
    if (fail_count <= 40)
      $display("%0t: %s mismatch, expected %0h got %0h", $time, what, exp_v, got_v);
  endtask

  // One bus tick: take a command if idle, then make one pin change or one poll.
  function automatic res_t bus_tick(logic [2:0] req, logic [7:0] tx, logic nack, logic sda);
    res_t       r;
    logic       fin;
    logic       stay;
    logic [5:0] s;
    int         k;
    fin  = 1'b0;
    stay = 1'b0;
    if (act_cmd == CMD_IDLE && req >= CMD_START && req <= CMD_READ) begin
      act_cmd = cmd_t'(req);
      step    = '0;
      if (req == CMD_WRITE) begin
        shreg = tx;
        polls = '0;
        ack_q = '0;
      end else if (req == CMD_READ) begin
        shreg    = '0;
        nack_req = nack;
      end
    end
    s = step;
    k = int'(s) - 1;
    case (act_cmd)
      CMD_START, CMD_RESTART: begin
        case (s)
          6'd0: sda_q = 1'b1;
          6'd1: scl_q = 1'b1;
          6'd2: sda_q = 1'b0;
          default: begin
            scl_q = 1'b0;
            fin   = 1'b1;
          end
        endcase
      end
      CMD_STOP: begin
        case (s)
          6'd0: scl_q = 1'b0;
          6'd1: sda_q = 1'b0;
          6'd2: scl_q = 1'b1;
          default: begin
            sda_q = 1'b1;
            fin   = 1'b1;
          end
        endcase
      end
      CMD_WRITE: begin
        if (s == 6'd0) sda_q = 1'b1;
        else if (s <= WR_BITS_LAST) begin
          if (k % 3 == 0) scl_q = 1'b0;
          else if (k % 3 == 1) sda_q = shreg[7 - k / 3];
          else scl_q = 1'b1;
        end else if (s == WR_SCL_LOW) scl_q = 1'b0;
        else if (s == WR_SDA_REL) sda_q = 1'b1;
        else if (s == WR_SCL_HIGH) scl_q = 1'b1;
        else if (s == WR_POLL_STEP) begin
          if (!sda) ack_q = 2'b01;
          else begin
            polls = polls + 8'd1;
            if (polls >= poll_limit) ack_q = 2'b10;
            else stay = 1'b1;
          end
        end else begin
          scl_q = 1'b0;
          fin   = 1'b1;
        end
      end
      CMD_READ: begin
        if (s == 6'd0) sda_q = 1'b1;
        else if (s <= RD_BITS_LAST) begin
          if (k % 2 == 0) scl_q = 1'b0;
          else begin
            scl_q = 1'b1;
            shreg = {shreg[6:0], sda};
          end
        end else if (s == RD_SCL_LOW) scl_q = 1'b0;
        else if (s == RD_ACK_DRIVE) sda_q = nack_req;
        else if (s == RD_SCL_HIGH) scl_q = 1'b1;
        else begin
          scl_q = 1'b0;
          rx_q  = shreg;
          fin   = 1'b1;
        end
      end
      default: stay = 1'b1;
    endcase
    if (fin) begin
      act_cmd = CMD_IDLE;
      step    = '0;
    end else if (!stay) begin
      step = s + 6'd1;
    end
    r.scl_out       = scl_q;
    r.sda_out       = sda_q;
    r.busy_res      = (act_cmd != CMD_IDLE);
    r.done_res      = fin;
    r.rx_byte       = rx_q;
    r.ack_received  = ack_q[0];
    r.ack_timed_out = ack_q[1];
    return r;
  endfunction

  always @(posedge clk) begin
    res_t exp_r;
    if (rst) begin
      act_cmd    = CMD_IDLE;
      step       = '0;
      shreg      = '0;
      polls      = '0;
      poll_limit = ACK_POLL_RESET;
      nack_req   = 1'b0;
      scl_q      = 1'b1;
      sda_q      = 1'b1;
      ack_q      = '0;
      rx_q       = '0;
      bus_results.delete();
    end else begin
      if (out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
        if (bus_results.size() == 0) begin
          report("unexpected result", 0, 1);
        end else begin
          exp_r = bus_results.pop_front();
          if (out_ch.scl_out !== exp_r.scl_out)
            report("scl_out", exp_r.scl_out, out_ch.scl_out);
          if (out_ch.sda_out !== exp_r.sda_out)
            report("sda_out", exp_r.sda_out, out_ch.sda_out);
          if (out_ch.busy_res !== exp_r.busy_res)
            report("busy_res", exp_r.busy_res, out_ch.busy_res);
          if (out_ch.done_res !== exp_r.done_res)
            report("done_res", exp_r.done_res, out_ch.done_res);
          if (out_ch.rx_byte !== exp_r.rx_byte)
            report("rx_byte", exp_r.rx_byte, out_ch.rx_byte);
          if (out_ch.ack_received !== exp_r.ack_received)
            report("ack_received", exp_r.ack_received, out_ch.ack_received);
          if (out_ch.ack_timed_out !== exp_r.ack_timed_out)
            report("ack_timed_out", exp_r.ack_timed_out, out_ch.ack_timed_out);
        end
      end
      if (cfg_we === 1'b1) poll_limit = cfg_data;
      if (in_ch.valid === 1'b1 && in_ch.ready === 1'b1)
        bus_results.push_back(bus_tick(in_ch.req_type, in_ch.tx_byte,
                                       in_ch.send_nack, in_ch.sda_in));
    end
    pending     = bus_results.size();
    engine_busy = (act_cmd != CMD_IDLE);
  end

endmodule

[verif/testbench.sv]
`timescale 1ns / 1ps
// Top of the I2C byte engine bench: clock, reset, tick traffic, result sink and verdict.
module testbench;
  import i2cm_pkg::*;

  // Request codes the engine has no command for; they must act as plain ticks.
  localparam logic [2:0]  REQ_UNUSED_LO = 3'd6;
  localparam logic [2:0]  REQ_UNUSED_HI = 3'd7;
  // ack_after value that never pulls SDA low during the poll
  localparam int          NEVER_ACK     = 1000;
  // Watchdog limit, far above what a correct run needs.
  localparam int unsigned CYCLE_LIMIT   = 500000;

  logic        clk;
  logic        rst;
  logic        cfg_we;
  logic [7:0]  cfg_data;

  int unsigned fail_count;
  int unsigned pending;
  logic        engine_busy;

  // Traffic shaping, owned by the stimulus process.
  int          in_idle_pct;
  int          out_stall_pct;
  bit          hold_req;
  logic [7:0]  cur_limit;
  int          ticks_sent;

  i2cm_in_if  in_ch();
  i2cm_out_if out_ch();

  i2c_master_byte_engine u_top (
    .clk      (clk),
    .rst      (rst),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data)
  );

  i2cm_checker u_checker (
    .clk         (clk),
    .rst         (rst),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .cfg_we      (cfg_we),
    .cfg_data    (cfg_data),
    .fail_count  (fail_count),
    .pending     (pending),
    .engine_busy (engine_busy)
  );

  initial clk = 1'b0;
  always #1 clk = ~clk;

  // Offer one tick and hold it until the engine takes it. Random gaps go in
  // front, so an idle stretch can land on any step of a running sequence.
  task automatic put_tick(logic [2:0] req, logic [7:0] tx, logic nack, logic sda);
    while ($urandom_range(99) < in_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.req_type  <= req;
    in_ch.tx_byte   <= tx;
    in_ch.send_nack <= nack;
    in_ch.sda_in    <= sda;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    ticks_sent++;
  endtask

  // One command followed by exactly the ticks it needs to finish.
  //   data:      byte to write, or the byte the slave puts on SDA for a read
  //   ack_after: for a write, number of polls that see SDA high before the ack
  //   noise_pct: chance that a follow-on tick carries a (dropped) command
  //   cut:       stop early, leaving the sequence half done
  task automatic run_sequence(logic [2:0] cmd, logic [7:0] data, logic nack,
                              int ack_after, int noise_pct, bit cut);
    int         n;
    int         polls_max;
    int         polls;
    logic [2:0] req;
    logic       sda;
    case (cmd)
      CMD_WRITE: begin
        polls_max = (cur_limit == 8'd0) ? 1 : int'(cur_limit);
        polls     = (ack_after < polls_max) ? ack_after + 1 : polls_max;
        n         = int'(WR_POLL_STEP) + polls + 1;
      end
      CMD_READ: n = int'(RD_SCL_HIGH) + 2;
      default:  n = 4;
    endcase
    if (cut) n = $urandom_range(n - 1, 1);
    for (int i = 0; i < n; i++) begin
      if (i == 0) req = cmd;
      else if ($urandom_range(99) < noise_pct) req = 3'($urandom_range(7));
      else req = CMD_IDLE;
      sda = 1'($urandom_range(1));
      // Poll ticks: SDA high until the chosen poll, then low (ack).
      if (cmd == CMD_WRITE && i >= int'(WR_POLL_STEP))
        sda = (i - int'(WR_POLL_STEP) == ack_after) ? 1'b0 : 1'b1;
      // Read sample ticks are the even steps 2..16, MSB first.
      if (cmd == CMD_READ && i >= 2 && i <= int'(RD_BITS_LAST) && i % 2 == 0)
        sda = data[8 - i / 2];
      put_tick(req, (i == 0) ? data : 8'($urandom_range(255)),
               (i == 0) ? nack : 1'($urandom_range(1)), sda);
    end
  endtask

  // Mostly well-formed sequences with random content; some stray ticks with
  // no command (incl. unused codes) and some sequences broken off midway.
  task automatic random_traffic(int n_ticks);
    int         first;
    int         pick;
    int         ack_after;
    logic [2:0] cmd;
    first = ticks_sent;
    while (ticks_sent - first < n_ticks) begin
      pick = $urandom_range(99);
      if (pick < 35) cmd = CMD_WRITE;
      else if (pick < 65) cmd = CMD_READ;
      else cmd = 3'($urandom_range(CMD_RESTART, CMD_START));
      pick = $urandom_range(99);
      if (pick < 70) ack_after = $urandom_range(3);
      else if (pick < 90) ack_after = $urandom_range(int'(cur_limit) + 1);
      else ack_after = NEVER_ACK;
      pick = $urandom_range(99);
      if (pick < 10) begin
        repeat ($urandom_range(3, 1)) begin
          case ($urandom_range(2))
            0:       cmd = CMD_IDLE;
            1:       cmd = REQ_UNUSED_LO;
            default: cmd = REQ_UNUSED_HI;
          endcase
          put_tick(cmd, 8'($urandom_range(255)), 1'($urandom_range(1)),
                   1'($urandom_range(1)));
        end
      end else begin
        run_sequence(cmd, 8'($urandom_range(255)), 1'($urandom_range(1)), ack_after, 5,
                     pick < 16);
      end
    end
  endtask

  // Wait for every result; if a broken-off sequence is still running, tick
  // it to completion so the register write below lands on an idle engine.
  task automatic settle();
    logic still_busy;
    in_ch.valid <= 1'b0;
    forever begin
      do @(negedge clk); while (pending != 0);
      still_busy = engine_busy;
      @(posedge clk);
      if (!still_busy) break;
      put_tick(CMD_IDLE, 8'h00, 1'b0, 1'b1);
      in_ch.valid <= 1'b0;
    end
    // leave a little margin after the last result
    repeat (2) @(posedge clk);
  endtask

  task automatic set_poll_limit(logic [7:0] v);
    cfg_we    <= 1'b1;
    cfg_data  <= v;
    cur_limit  = v;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // Result side: random stalls per phase, plus one long hold-off on request
  // so the queue fills and the input side backs up.
  initial begin : result_sink
    int hold_left;
    hold_left    = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = 64;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= out_stall_pct);
      end
    end
  end

  initial begin : watchdog
    int unsigned cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("testbench: FAIL");
    $finish;
  end

  initial begin : stimulus
    rst             = 1'b1;
    cfg_we          = 1'b0;
    cfg_data        = 8'h00;
    in_ch.valid     = 1'b0;
    in_ch.req_type  = CMD_IDLE;
    in_ch.tx_byte   = 8'h00;
    in_ch.send_nack = 1'b0;
    in_ch.sda_in    = 1'b1;
    in_idle_pct     = 0;
    out_stall_pct   = 0;
    hold_req        = 1'b0;
    cur_limit       = ACK_POLL_RESET;
    ticks_sent      = 0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed, reset poll limit, no idling on either side.
    put_tick(CMD_IDLE, 8'h00, 1'b0, 1'b1);
    put_tick(REQ_UNUSED_LO, 8'hFF, 1'b1, 1'b0);
    put_tick(REQ_UNUSED_HI, 8'hFF, 1'b1, 1'b0);
    run_sequence(CMD_START, 8'h00, 1'b0, 0, 0, 1'b0);
    run_sequence(CMD_WRITE, 8'hFF, 1'b0, 0, 0, 1'b0);          // ack on first poll
    run_sequence(CMD_WRITE, 8'h00, 1'b1, NEVER_ACK, 0, 1'b0);  // ack times out
    run_sequence(CMD_WRITE, 8'hA5, 1'b0, 3, 0, 1'b0);          // ack after a few polls
    run_sequence(CMD_READ, 8'hFF, 1'b1, 0, 0, 1'b0);           // all ones, NACK
    run_sequence(CMD_READ, 8'h00, 1'b0, 0, 0, 1'b0);           // all zeros, ACK
    run_sequence(CMD_RESTART, 8'h00, 1'b0, 0, 0, 1'b0);
    run_sequence(CMD_READ, 8'h5A, 1'b0, 0, 100, 1'b0);         // commands while busy
    run_sequence(CMD_STOP, 8'hFF, 1'b1, 0, 100, 1'b0);

    // Back-pressure: long receiver hold while the sender keeps offering.
    hold_req = 1'b1;
    random_traffic(40);
    settle();

    // Poll limit of one, sender idles often.
    set_poll_limit(8'd1);
    in_idle_pct   = 63;
    out_stall_pct = 0;
    random_traffic(50);
    settle();

    // Zero poll limit: single poll that times out unless SDA is low.
    set_poll_limit(8'd0);
    in_idle_pct   = 0;
    out_stall_pct = 63;
    run_sequence(CMD_WRITE, 8'h81, 1'b0, NEVER_ACK, 0, 1'b0);
    run_sequence(CMD_WRITE, 8'h7E, 1'b0, 0, 0, 1'b0);
    random_traffic(40);
    settle();

    // Maximum poll limit, one full timeout, both sides idling.
    set_poll_limit(8'd255);
    in_idle_pct   = 32;
    out_stall_pct = 32;
    run_sequence(CMD_WRITE, 8'h3C, 1'b0, NEVER_ACK, 0, 1'b0);
    random_traffic(20);
    settle();

    // Random mid-range limit, full rate.
    set_poll_limit(8'($urandom_range(12, 2)));
    in_idle_pct   = 0;
    out_stall_pct = 0;
    random_traffic(40);
    settle();

    repeat (4) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule

[i2c_master_byte_engine.f]
+incdir+sv
sv/i2cm_pkg.sv
sv/i2cm_if.sv
sv/i2cm_front.sv
sv/i2cm_back.sv
sv/i2c_master_byte_engine.sv
verif/i2cm_checker.sv
verif/testbench.sv
